[hw/rtl/mi_pkg.sv]
`default_nettype none

package mi_pkg;

  // Default working width of the Euclid datapath
  localparam int unsigned WIDTH_DEF = 32;

  // Fixed width of the value, modulus and inverse ports
  localparam int unsigned FIELD_W = 32;

  // Request from the sequencer to the shared divide unit
  typedef struct packed {
    logic start;
  } div_req_t;

  // Status back from the shared divide unit
  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

`default_nettype wire

[hw/rtl/modular_inverse.sv]
`default_nettype none

// Channel  | Direction | Ports                              | Handshake
// ---------+-----------+------------------------------------+--------------------
// in       | input     | in_value, in_modulus               | in_valid / in_stall
// out      | output    | out_inverse, out_status            | out_valid / out_stall
//
// Each word runs I Euclid iterations (I is at most about 1.44 * WIDTH), and
// each iteration runs one division in the shared shift-subtract divider,
// which also accumulates q * nt.
// rst_n is synchronous; it drops any word in flight and empties the output.
// in_stall is high from accept until the result is loaded into the output
// register; a result waiting on out_stall does not block the next input word.
module modular_inverse #(
  parameter int unsigned WIDTH = mi_pkg::WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [mi_pkg::FIELD_W-1:0] in_value,
  input  wire logic [mi_pkg::FIELD_W-1:0] in_modulus,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [mi_pkg::FIELD_W-1:0] out_inverse,
  output logic                            out_status
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [WIDTH-1:0] r_r, nr_r, t_r, nt_r, mod_r;
  logic             par_r;                  // parity of the coefficient index
  logic             ovalid_r, ovalid_nxt;
  logic [mi_pkg::FIELD_W-1:0] oinv_r;
  logic             ostat_r;

  logic             in_take, out_free;
  logic [63:0]      val_ext, mod_ext, inv_ext;
  logic [WIDTH-1:0] inv_w;
  logic             not_inv, neg;

  mi_pkg::div_req_t div_req;
  mi_pkg::div_rsp_t div_rsp;
  logic [WIDTH-1:0] div_rem, div_prod;

  mi_div #(.WIDTH(WIDTH)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .rsp      (div_rsp),
    .dividend (r_r),
    .divisor  (nr_r),
    .coef     (nt_r),
    .rem      (div_rem),
    .prod     (div_prod)
  );

  // Fit the 32-bit port words to the working width
  assign val_ext = 64'(in_value);
  assign mod_ext = 64'(in_modulus);

  assign in_stall = !rst_n || (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !ovalid_r || !out_stall;

  // Final gcd above one means no inverse; fold a negative coefficient once
  always_comb begin
    not_inv = (r_r > WIDTH'(1));
    neg     = !par_r && (t_r != '0);
    inv_w   = not_inv ? '0 : (neg ? (mod_r - t_r) : t_r);
    inv_ext = 64'(inv_w);
  end

  always_comb begin
    state_nxt     = state_r;
    div_req.start = 1'b0;
    ovalid_nxt    = ovalid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_take) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (nr_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) state_nxt = ST_CHECK;
      end
      ST_FIN: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Remainder and coefficient pairs: load on accept, advance on each quotient
  always_ff @(posedge clk) begin
    if (in_take) begin
      r_r   <= mod_ext[WIDTH-1:0];
      nr_r  <= val_ext[WIDTH-1:0];
      mod_r <= mod_ext[WIDTH-1:0];
      t_r   <= '0;
      nt_r  <= WIDTH'(1);
      par_r <= 1'b0;
    end else if (state_r == ST_DIV && div_rsp.done) begin
      r_r   <= nr_r;
      nr_r  <= div_rem;
      t_r   <= nt_r;
      nt_r  <= t_r + div_prod;
      par_r <= !par_r;
    end
  end

  // Output register: hold while stalled, load when the slot frees up
  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && out_free) begin
      oinv_r  <= inv_ext[mi_pkg::FIELD_W-1:0];
      ostat_r <= not_inv;
    end
  end

  assign out_valid   = ovalid_r;
  assign out_inverse = oinv_r;
  assign out_status  = ostat_r;

endmodule

`default_nettype wire

[hw/rtl/mi_div.sv]
`default_nettype none

// Restoring divider, one quotient bit a cycle, MSB first. The same quotient
// bits drive a shift-add accumulator so that q * coef (mod 2^WIDTH) is ready
// together with the remainder.
module mi_div #(
  parameter int unsigned WIDTH = mi_pkg::WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mi_pkg::div_req_t req,
  output mi_pkg::div_rsp_t      rsp,
  input  wire logic [WIDTH-1:0] dividend,
  input  wire logic [WIDTH-1:0] divisor,
  input  wire logic [WIDTH-1:0] coef,
  output logic      [WIDTH-1:0] rem,
  output logic      [WIDTH-1:0] prod
);

  localparam int unsigned CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] dvd_r, div_r, coef_r, rem_r, prod_r;
  logic [WIDTH-1:0] dvd_nxt, rem_nxt, prod_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [WIDTH:0]   rem_sh;
  logic [WIDTH:0]   rem_sub;
  logic             qbit;

  always_comb begin
    rem_sh   = {rem_r, dvd_r[WIDTH-1]};
    qbit     = (rem_sh >= {1'b0, div_r});
    rem_sub  = rem_sh - {1'b0, div_r};
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    prod_nxt = prod_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      prod_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt  = {dvd_r[WIDTH-2:0], 1'b0};
      rem_nxt  = qbit ? rem_sub[WIDTH-1:0] : rem_sh[WIDTH-1:0];
      prod_nxt = {prod_r[WIDTH-2:0], 1'b0} + (qbit ? coef_r : '0);
      cnt_nxt  = cnt_r + CW'(1);
      if (cnt_r == CW'(WIDTH - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    prod_r <= prod_nxt;
    if (req.start) begin
      div_r  <= divisor;
      coef_r <= coef;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rem      = rem_r;
  assign prod     = prod_r;

endmodule

`default_nettype wire

[hw/rtl/mi_checker.sv]
`default_nettype none

module mi_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [mi_pkg::FIELD_W-1:0] out_inverse,
  input wire logic                       out_status
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_inverse) && $stable(out_status))
    else $error("result word changed under stall");

  // Not invertible always reports a zero inverse
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_inverse == '0)
    else $error("nonzero inverse with not-invertible status");

  // The block goes busy right after taking a word
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // A new result only appears while a word was in work
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no word in work");

endmodule

bind modular_inverse mi_checker u_mi_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_inverse (out_inverse),
  .out_status  (out_status)
);

`default_nettype wire
